@@ hdl/aes128_block_encrypt_assert.svh @@
// ---------------------------------------------------------------------------
// AES-128 assertion macros
// Shared concurrent assertion forms for the cipher checker.
// ---------------------------------------------------------------------------
`ifndef AES128_BLOCK_ENCRYPT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_ASSERT_SVH

// same-cycle implication, clocked on clk, held off during reset
`define AES_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aes128 check failed: same-cycle rule");

// next-cycle implication, clocked on clk, held off during reset
`define AES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aes128 check failed: next-cycle rule");

`endif

@@ hdl/aes_pkg.sv @@
// ---------------------------------------------------------------------------
// AES-128 package
// S-box, round constants, GF(2^8) helper and sequencer state type.
// ---------------------------------------------------------------------------
package aes_pkg;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} aes_state_t;

	typedef logic [3:0] rnd_t;

	localparam int unsigned KEY_BITS = 128;
	localparam rnd_t FIRST_RND = 4'd1;
	localparam rnd_t LAST_RND  = 4'd10;

	// configuration register indexes
	localparam logic CFG_KEY_LOW  = 1'b0;
	localparam logic CFG_KEY_HIGH = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] rcon(input rnd_t r);
		logic [7:0] c;
		case (r)
			4'd1:    c = 8'h01;
			4'd2:    c = 8'h02;
			4'd3:    c = 8'h04;
			4'd4:    c = 8'h08;
			4'd5:    c = 8'h10;
			4'd6:    c = 8'h20;
			4'd7:    c = 8'h40;
			4'd8:    c = 8'h80;
			4'd9:    c = 8'h1b;
			4'd10:   c = 8'h36;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

@@ hdl/aes_rnd.sv @@
// ---------------------------------------------------------------------------
// AES-128 round unit
// One key schedule step and one cipher round, shared by all ten rounds.
// ---------------------------------------------------------------------------
module aes_rnd (
	input  logic [127:0] state_in,
	input  logic [127:0] key_in,
	input  logic [7:0]   rcon_in,
	input  logic         final_rnd,
	output logic [127:0] key_out,
	output logic [127:0] state_out
);
	import aes_pkg::*;

	logic [7:0] kc [16];
	logic [7:0] kn [16];
	logic [7:0] sb [16];
	logic [7:0] mc [16];
	logic [7:0] sc [16];

	// key schedule: SubWord(RotWord(w3)) ^ rcon, then xor chain
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			kc[i] = key_in[8*i +: 8];
		end
		kn[0] = kc[0] ^ SBOX[kc[13]] ^ rcon_in;
		kn[1] = kc[1] ^ SBOX[kc[14]];
		kn[2] = kc[2] ^ SBOX[kc[15]];
		kn[3] = kc[3] ^ SBOX[kc[12]];
		for (int i = 4; i < 16; i++) begin
			kn[i] = kc[i] ^ kn[i-4];
		end
		for (int i = 0; i < 16; i++) begin
			key_out[8*i +: 8] = kn[i];
		end
	end

	// SubBytes + ShiftRows, then MixColumns unless final
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sb[r + 4*c] = SBOX[state_in[8*(r + 4*((c + r) % 4)) +: 8]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			sc[4*c]   = sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
			mc[4*c]   = sb[4*c]   ^ sc[4*c] ^ xtime(sb[4*c]   ^ sb[4*c+1]);
			mc[4*c+1] = sb[4*c+1] ^ sc[4*c] ^ xtime(sb[4*c+1] ^ sb[4*c+2]);
			mc[4*c+2] = sb[4*c+2] ^ sc[4*c] ^ xtime(sb[4*c+2] ^ sb[4*c+3]);
			mc[4*c+3] = sb[4*c+3] ^ sc[4*c] ^ xtime(sb[4*c+3] ^ sb[4*c]);
			sc[4*c+1] = 8'h00;
			sc[4*c+2] = 8'h00;
			sc[4*c+3] = 8'h00;
		end
		for (int i = 0; i < 16; i++) begin
			state_out[8*i +: 8] = (final_rnd ? sb[i] : mc[i]) ^ kn[i];
		end
	end

endmodule

@@ hdl/aes128_block_encrypt.sv @@
// ---------------------------------------------------------------------------
// AES-128 block encrypt
// Iterative FIPS-197 AES-128 encryption core, ECB, one round per clock while not stalled.
// ---------------------------------------------------------------------------
// A plaintext transaction is taken only while the core is idle. The initial
// AddRoundKey is done on accept; the shared round unit then runs the ten
// rounds, one per clock while not stalled, expanding each round key on the
// fly from the key registers; the ciphertext is in the output register the
// cycle after the tenth round. The output register lets the next block be
// accepted while a ciphertext waits; only the last round stalls if the
// previous ciphertext is still not taken. Bytes use the little-endian
// layout: byte 0 is plain_low[7:0], byte 15 is plain_high[63:56]. Key
// halves are written through cfg_we/cfg_index/cfg_wdata (index 0 = low,
// 1 = high) and must only be written while no block is in flight.
// end_of_batch rides along untouched to end_of_batch_out.
module aes128_block_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        plain_valid,
	output logic        plain_ready,
	input  logic [63:0] plain_low,
	input  logic [63:0] plain_high,
	input  logic        end_of_batch,
	output logic        cipher_valid,
	input  logic        cipher_ready,
	output logic [63:0] cipher_low,
	output logic [63:0] cipher_high,
	output logic        end_of_batch_out
);
	import aes_pkg::*;

	aes_state_t  state_q, state_d;
	logic [127:0] key_q;      // cipher key, reset to zero
	logic [127:0] st_q;       // working state
	logic [127:0] rk_q;       // previous round key
	rnd_t         rnd_q;
	logic         eob_q;
	logic         cvalid_q;
	logic [127:0] cipher_q;
	logic         ceob_q;

	logic         accept;
	logic         step;
	logic         last;
	logic [127:0] rnd_key;
	logic [127:0] rnd_state;

	aes_rnd u_rnd (
		.state_in  (st_q),
		.key_in    (rk_q),
		.rcon_in   (rcon(rnd_q)),
		.final_rnd (last),
		.key_out   (rnd_key),
		.state_out (rnd_state)
	);

	// sequencer
	always_comb begin
		state_d     = state_q;
		plain_ready = 1'b0;
		last        = (rnd_q == LAST_RND);
		step        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				plain_ready = 1'b1;
				if (plain_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				// last round waits for room in the output register
				step = !last || !cvalid_q || cipher_ready;
				if (step && last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = plain_valid && plain_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rnd_q    <= FIRST_RND;
			cvalid_q <= 1'b0;
			key_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rnd_q <= FIRST_RND;
			end else if (step) begin
				rnd_q <= rnd_q + 4'd1;
			end
			if (step && last) begin
				cvalid_q <= 1'b1;
			end else if (cipher_ready) begin
				cvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LOW:  key_q[63:0]   <= cfg_wdata;
					CFG_KEY_HIGH: key_q[127:64] <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			st_q  <= {plain_high, plain_low} ^ key_q;
			rk_q  <= key_q;
			eob_q <= end_of_batch;
		end else if (step) begin
			st_q <= rnd_state;
			rk_q <= rnd_key;
		end
		if (step && last) begin
			cipher_q <= rnd_state;
			ceob_q   <= eob_q;
		end
	end

	assign cipher_valid     = cvalid_q;
	assign cipher_low       = cipher_q[63:0];
	assign cipher_high      = cipher_q[127:64];
	assign end_of_batch_out = ceob_q;

endmodule

@@ hdl/aes_chk.sv @@
// ---------------------------------------------------------------------------
// AES-128 port checker
// Port-level assertions on the cipher core, attached by bind.
// ---------------------------------------------------------------------------
`include "aes128_block_encrypt_assert.svh"

module aes_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        plain_valid,
	input logic        plain_ready,
	input logic        cipher_valid,
	input logic        cipher_ready,
	input logic [63:0] cipher_low
);
	// core is busy right after taking a block
	`AES_ASSERT_NEXT(a_busy_after_accept, plain_valid && plain_ready, !plain_ready)
	// no ciphertext can appear in the cycle after accept into an empty output
	`AES_ASSERT_NEXT(a_no_early_out, plain_valid && plain_ready && !cipher_valid, !cipher_valid)
	// pending ciphertext holds
	`AES_ASSERT_NEXT(a_out_hold, cipher_valid && !cipher_ready, cipher_valid)
	`AES_ASSERT_NEXT(a_out_stable, cipher_valid && !cipher_ready, $stable(cipher_low))
	// a core coming back to idle has just loaded a ciphertext
	`AES_ASSERT_NOW(a_ready_idle, plain_ready && !$past(plain_ready), cipher_valid)

endmodule

bind aes128_block_encrypt aes_chk u_aes_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.plain_valid  (plain_valid),
	.plain_ready  (plain_ready),
	.cipher_valid (cipher_valid),
	.cipher_ready (cipher_ready),
	.cipher_low   (cipher_low)
);
